### rtl/tsg_pkg.sv
// shared types, constants and sine table builder for the tone sequence generator
`default_nettype none
package tsg_pkg;

    localparam int SEGMENTS   = 16;
    localparam int WAVES      = 4;
    localparam int SINE_DEPTH = 256;
    localparam int SEG_W      = $clog2(SEGMENTS);
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int FREQ_W     = 15;
    localparam int DUR_W      = 16;
    localparam int AMP_W      = 15;
    localparam int PCM_W      = 16;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int MAG_W      = 31;
    localparam int FIELD_FREQS = 4;

    localparam logic [DUR_W-1:0] ENDLESS_MS = 16'hFFFF;

    localparam longint Q30     = 64'sd1073741824;
    localparam longint SIN_C1  = 64'sd1686629713;
    localparam longint SIN_C3  = 64'sd693598669;
    localparam longint SIN_C5  = 64'sd85569306;
    localparam longint SIN_C7  = 64'sd5026995;
    localparam longint SIN_C9  = 64'sd172273;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_STARTING,
        MODE_PLAYING,
        MODE_STOPPING
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLES_PER_MS = 3'd0,
        CFG_PHASE_SCALE    = 3'd1,
        CFG_REPEAT_COUNT   = 3'd2,
        CFG_REPEAT_SEGMENT = 3'd3,
        CFG_AMPLITUDE      = 3'd4
    } t_cfg_idx;

    // decoded input item passed from front to sequencer
    typedef struct packed {
        t_opcode                       op;
        logic [3:0]                    slot;
        logic [DUR_W-1:0]              dur;
        logic [WAVES-1:0][FREQ_W-1:0]  freq;
        logic [7:0]                    loop_times;
        logic [3:0]                    loop_target;
    } t_cmd;

    // sample request from sequencer to wave datapath
    typedef struct packed {
        logic [SEG_W-1:0]              seg;
        logic                          done;
        logic [WAVES-1:0]              mask;
        logic [WAVES-1:0][31:0]        phase;
    } t_wave_req;

    typedef logic [MAG_W-1:0] t_sine_lut [SINE_DEPTH];

    // sine magnitude per table step, q30, built at elaboration
    function automatic t_sine_lut build_sine_lut();
        t_sine_lut lut;
        longint    t;
        longint    u;
        longint    z2;
        longint    acc;
        for (int i = 0; i < SINE_DEPTH; i++) begin
            t = (longint'(i) <<< 32) / SINE_DEPTH;
            u = t & 64'sh7FFF_FFFF;
            if (u > 64'sh4000_0000) begin
                u = 64'sh8000_0000 - u;
            end
            z2  = (u * u) / Q30;
            acc = SIN_C9;
            acc = (acc * z2) / Q30 - SIN_C7;
            acc = (acc * z2) / Q30 + SIN_C5;
            acc = (acc * z2) / Q30 - SIN_C3;
            acc = (acc * z2) / Q30 + SIN_C1;
            acc = (acc * u) / Q30;
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > Q30) begin
                acc = Q30;
            end
            lut[i] = MAG_W'(acc);
        end
        return lut;
    endfunction

endpackage
`default_nettype wire

### rtl/tsg_in_if.sv
// input item channel
`default_nettype none
interface tsg_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [3:0]  seg_slot;
    logic [15:0] seg_duration_ms;
    logic [14:0] freq_a;
    logic [14:0] freq_b;
    logic [14:0] freq_c;
    logic [14:0] freq_d;
    logic [7:0]  loop_times;
    logic [3:0]  loop_target;

    modport source (output valid, opcode, seg_slot, seg_duration_ms, freq_a, freq_b,
                    freq_c, freq_d, loop_times, loop_target, input ready);
    modport sink   (input valid, opcode, seg_slot, seg_duration_ms, freq_a, freq_b,
                    freq_c, freq_d, loop_times, loop_target, output ready);
endinterface
`default_nettype wire

### rtl/tsg_out_if.sv
// result item channel
`default_nettype none
interface tsg_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pcm_sample;
    logic [3:0]         active_segment;
    logic               tone_done;

    modport source (output valid, pcm_sample, active_segment, tone_done, input ready);
    modport sink   (input valid, pcm_sample, active_segment, tone_done, output ready);
endinterface
`default_nettype wire

### rtl/tsg_front.sv
// front end: accepts and decodes input items into a two-entry queue
`default_nettype none
module tsg_front (
    input  wire            i_clk,
    input  wire            i_rst_n,
    tsg_in_if.sink         i_item,
    input  wire            i_pop,
    output logic           o_valid,
    output tsg_pkg::t_cmd  o_cmd
);
    import tsg_pkg::*;

    t_cmd       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    t_cmd       dec;
    logic       push;
    logic       pop;
    logic [FIELD_FREQS-1:0][FREQ_W-1:0] fields;

    // decode the item fields
    always_comb begin
        fields = {i_item.freq_d, i_item.freq_c, i_item.freq_b, i_item.freq_a};
        dec.op          = t_opcode'(i_item.opcode);
        dec.slot        = i_item.seg_slot;
        dec.dur         = i_item.seg_duration_ms;
        dec.loop_times  = i_item.loop_times;
        dec.loop_target = i_item.loop_target;
        for (int k = 0; k < WAVES; k++) begin
            dec.freq[k] = (k < FIELD_FREQS) ? fields[k % FIELD_FREQS] : '0;
        end
    end

    assign i_item.ready = (r_cnt != 2'd2);
    assign push    = i_item.valid && i_item.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_pop;
    assign o_cmd   = r_q[r_rd];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= dec;
        end
    end
endmodule
`default_nettype wire

### rtl/tsg_seq.sv
// sequencer: segment table, config, player state and phase accumulators
`default_nettype none
module tsg_seq (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [tsg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [tsg_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire                         i_valid,
    input  wire tsg_pkg::t_cmd          i_cmd,
    input  wire                         i_en,
    output logic                        o_req_valid,
    output tsg_pkg::t_wave_req          o_req,
    output logic [tsg_pkg::AMP_W-1:0]   o_amplitude
);
    import tsg_pkg::*;

    // config registers
    logic [7:0]       r_spm;
    logic [31:0]      r_scale;
    logic [7:0]       r_rep_count;
    logic [3:0]       r_rep_seg;
    logic [AMP_W-1:0] r_amp;

    // segment table
    logic [DUR_W-1:0]  r_dur   [SEGMENTS];
    logic [FREQ_W-1:0] r_freq  [SEGMENTS][WAVES];
    logic [7:0]        r_ltime [SEGMENTS];
    logic [3:0]        r_ltgt  [SEGMENTS];

    // player state
    t_mode            r_mode, n_mode;
    logic [SEG_W-1:0] r_cur, n_cur;
    logic [7:0]       r_loop, n_loop;
    logic [7:0]       r_rep, n_rep;
    logic [31:0]      r_total, n_total;
    logic [31:0]      r_bound, n_bound;
    logic [31:0]      r_phase [WAVES];
    logic [31:0]      n_phase [WAVES];
    logic             r_req_valid, n_req_valid;
    t_wave_req        r_req, n_req;

    logic [SEG_W-1:0]  cand, newseg, sel_seg;
    logic [7:0]        loop_nx, rep_nx;
    logic              ok, new_live, trans, take;
    logic [31:0]       total_nx;
    logic [WAVES-1:0]  mask;
    logic [31:0]       inc [WAVES];
    logic              live;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] seg_len(input logic [DUR_W-1:0] ms,
                                            input logic [7:0] spm);
        logic [23:0] p;
        p = {8'd0, ms} * {16'd0, spm};
        return (ms == ENDLESS_MS) ? 32'hFFFF_FFFF : {8'd0, p};
    endfunction

    assign take        = i_valid && i_en;
    assign o_req_valid = r_req_valid;
    assign o_req       = r_req;
    assign o_amplitude = r_amp;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm       <= 8'd48;
            r_scale     <= 32'd89478;
            r_rep_count <= 8'd0;
            r_rep_seg   <= 4'd0;
            r_amp       <= 15'd16000;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SAMPLES_PER_MS: r_spm       <= i_cfg_data[7:0];
                CFG_PHASE_SCALE:    r_scale     <= i_cfg_data;
                CFG_REPEAT_COUNT:   r_rep_count <= i_cfg_data[7:0];
                CFG_REPEAT_SEGMENT: r_rep_seg   <= i_cfg_data[3:0];
                CFG_AMPLITUDE:      r_amp       <= i_cfg_data[AMP_W-1:0];
                default: ;
            endcase
        end
    end

    // segment table loads
    always_ff @(posedge i_clk) begin
        if (take && i_cmd.op == OP_LOAD && 32'(i_cmd.slot) < SEGMENTS) begin
            r_dur[SEG_W'(i_cmd.slot)]   <= i_cmd.dur;
            r_ltime[SEG_W'(i_cmd.slot)] <= i_cmd.loop_times;
            r_ltgt[SEG_W'(i_cmd.slot)]  <= i_cmd.loop_target;
            for (int k = 0; k < WAVES; k++) begin
                r_freq[SEG_W'(i_cmd.slot)][k] <= i_cmd.freq[k];
            end
        end
    end

    // next segment by loop and repeat rules
    always_comb begin
        if (r_ltime[r_cur] != 8'd0 && r_loop < r_ltime[r_cur]) begin
            cand    = SEG_W'(32'(r_ltgt[r_cur]) % SEGMENTS);
            loop_nx = r_loop + 8'd1;
        end else begin
            loop_nx = (r_ltime[r_cur] != 8'd0) ? 8'd0 : r_loop;
            cand    = (32'(r_cur) == SEGMENTS - 1) ? '0 : r_cur + SEG_W'(1);
        end
        newseg = cand;
        rep_nx = r_rep;
        ok     = 1'b1;
        if (r_dur[cand] == '0) begin
            if (r_rep < r_rep_count) begin
                newseg = SEG_W'(32'(r_rep_seg) % SEGMENTS);
                rep_nx = r_rep + 8'd1;
            end else begin
                ok = 1'b0;
            end
        end
        new_live = ok && (r_dur[newseg] != '0);
    end

    assign total_nx = sat_add(r_total, 32'd1);
    assign trans    = (r_mode == MODE_PLAYING) && (r_dur[r_cur] != '0)
                      && (total_nx > r_bound);
    assign sel_seg  = trans ? newseg : r_cur;

    // wave mask and phase steps of the selected segment
    always_comb begin
        live = 1'b1;
        for (int k = 0; k < WAVES; k++) begin
            live    = live && (r_freq[sel_seg][k] != '0);
            mask[k] = live;
            inc[k]  = {17'd0, r_freq[sel_seg][k]} * r_scale;
        end
    end

    // player next state
    always_comb begin
        n_mode      = r_mode;
        n_cur       = r_cur;
        n_loop      = r_loop;
        n_rep       = r_rep;
        n_total     = r_total;
        n_bound     = r_bound;
        n_phase     = r_phase;
        n_req_valid = 1'b0;
        n_req.seg   = r_cur;
        n_req.done  = 1'b0;
        n_req.mask  = '0;
        for (int k = 0; k < WAVES; k++) begin
            n_req.phase[k] = r_phase[k];
        end
        if (take) begin
            unique case (i_cmd.op)
                OP_START: begin
                    if (r_mode == MODE_IDLE) begin
                        n_cur   = '0;
                        n_loop  = 8'd0;
                        n_rep   = 8'd0;
                        n_total = 32'd0;
                        n_bound = seg_len(r_dur[0], r_spm);
                        for (int k = 0; k < WAVES; k++) begin
                            n_phase[k] = 32'd0;
                        end
                        n_mode  = MODE_STARTING;
                    end
                end
                OP_STOP: begin
                    if (r_mode != MODE_IDLE) begin
                        n_mode = MODE_STOPPING;
                    end
                end
                OP_TICK: begin
                    if (r_mode != MODE_IDLE) begin
                        n_total     = total_nx;
                        n_req_valid = 1'b1;
                        if (r_mode == MODE_STOPPING || r_dur[r_cur] == '0) begin
                            n_req.done = 1'b1;
                            n_mode     = MODE_IDLE;
                        end else if (r_mode == MODE_STARTING) begin
                            n_mode     = MODE_PLAYING;
                            n_req.mask = mask;
                            for (int k = 0; k < WAVES; k++) begin
                                n_req.phase[k] = 32'd0;
                                n_phase[k]     = mask[k] ? inc[k] : 32'd0;
                            end
                        end else if (!trans) begin
                            n_req.mask = mask;
                            for (int k = 0; k < WAVES; k++) begin
                                n_phase[k] = mask[k] ? r_phase[k] + inc[k] : r_phase[k];
                            end
                        end else begin
                            n_cur     = newseg;
                            n_loop    = loop_nx;
                            n_rep     = rep_nx;
                            n_req.seg = newseg;
                            if (!ok) begin
                                n_req.done = 1'b1;
                                n_mode     = MODE_IDLE;
                            end else begin
                                // new segment starts at phase zero, so its sample is silent
                                for (int k = 0; k < WAVES; k++) begin
                                    n_phase[k] = (new_live && mask[k]) ? inc[k] : 32'd0;
                                end
                                n_bound = sat_add(r_bound, seg_len(r_dur[newseg], r_spm));
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // player state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_IDLE;
            r_cur       <= '0;
            r_loop      <= 8'd0;
            r_rep       <= 8'd0;
            r_total     <= 32'd0;
            r_bound     <= 32'd0;
            r_req_valid <= 1'b0;
            for (int k = 0; k < WAVES; k++) begin
                r_phase[k] <= 32'd0;
            end
        end else if (i_en) begin
            r_mode      <= n_mode;
            r_cur       <= n_cur;
            r_loop      <= n_loop;
            r_rep       <= n_rep;
            r_total     <= n_total;
            r_bound     <= n_bound;
            r_req_valid <= n_req_valid;
            r_phase     <= n_phase;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_req <= n_req;
        end
    end
endmodule
`default_nettype wire

### rtl/tsg_wave.sv
// wave datapath: sine lookup and scaling, then summing into the output register
`default_nettype none
module tsg_wave (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_req_valid,
    input  wire tsg_pkg::t_wave_req    i_req,
    input  wire [tsg_pkg::AMP_W-1:0]   i_amplitude,
    output logic                       o_en,
    tsg_out_if.source                  o_sample
);
    import tsg_pkg::*;

    localparam t_sine_lut SINE_LUT = build_sine_lut();
    localparam int PROD_W = AMP_W + MAG_W;

    logic                   r_b_valid;
    logic [SEG_W-1:0]       r_b_seg;
    logic                   r_b_done;
    logic [PROD_W-1:0]      r_prod [WAVES];
    logic [WAVES-1:0]       r_neg;
    logic                   r_out_valid;
    logic [PCM_W-1:0]       r_pcm;
    logic [3:0]             r_seg;
    logic                   r_done;
    logic [PCM_W-1:0]       sum;
    logic [PCM_W-1:0]       mag;

    assign o_en = !r_out_valid || o_sample.ready;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (o_en) begin
            r_b_valid   <= i_req_valid;
            r_out_valid <= r_b_valid;
        end
    end

    // sine lookup and amplitude scaling per wave
    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_b_seg  <= i_req.seg;
            r_b_done <= i_req.done;
            for (int k = 0; k < WAVES; k++) begin
                r_neg[k]  <= i_req.phase[k][31];
                r_prod[k] <= i_req.mask[k]
                    ? {{MAG_W{1'b0}}, i_amplitude} *
                      {{AMP_W{1'b0}}, SINE_LUT[i_req.phase[k][31 -: SINE_AW]]}
                    : '0;
            end
        end
    end

    // wrap-around sum of the signed wave values
    always_comb begin
        sum = '0;
        mag = '0;
        for (int k = 0; k < WAVES; k++) begin
            mag = PCM_W'(r_prod[k] >> 30);
            sum = r_neg[k] ? sum - mag : sum + mag;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_pcm  <= sum;
            r_seg  <= 4'(r_b_seg);
            r_done <= r_b_done;
        end
    end

    assign o_sample.valid          = r_out_valid;
    assign o_sample.pcm_sample     = r_pcm;
    assign o_sample.active_segment = r_seg;
    assign o_sample.tone_done      = r_done;
endmodule
`default_nettype wire

### rtl/tone_sequence_generator.sv
// top level of the tone sequence generator
//
// Items on i_item carry an opcode: load writes one segment table entry, start
// arms the player, stop ends playback, and tick asks for one sample. Each tick
// while playing returns one item on o_sample: the summed sine sample, the
// segment that made it and a done flag on the final silent sample. Loads,
// starts, stops and ticks while idle return nothing.
// A two-entry queue sits in front of the sequencer; unless the output stalls,
// the sequencer handles one item per cycle, so the block sustains one item per
// cycle. A tick passes the queue, the sequencer register, sine lookup and
// scaling, then the summing output register; the phase update loop in the
// sequencer sets that rate. The user must configure via i_cfg_we /
// i_cfg_idx / i_cfg_data only while idle; the block does not enforce it. Reset
// clears the player to idle and the config registers to their defaults; the
// segment table holds nothing defined until loaded. When the receiver stalls,
// the pipeline holds and the queue fills, then i_item.ready drops.
`default_nettype none
module tone_sequence_generator (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    tsg_in_if.sink                       i_item,
    tsg_out_if.source                    o_sample,
    input  wire                          i_cfg_we,
    input  wire [tsg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [tsg_pkg::CFG_W-1:0]     i_cfg_data
);
    import tsg_pkg::*;

    logic             en;
    logic             cmd_valid;
    t_cmd             cmd;
    logic             req_valid;
    t_wave_req        req;
    logic [AMP_W-1:0] amplitude;

    tsg_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_pop   (en),
        .o_valid (cmd_valid),
        .o_cmd   (cmd)
    );

    tsg_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (cmd_valid),
        .i_cmd       (cmd),
        .i_en        (en),
        .o_req_valid (req_valid),
        .o_req       (req),
        .o_amplitude (amplitude)
    );

    tsg_wave u_wave (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .i_amplitude (amplitude),
        .o_en        (en),
        .o_sample    (o_sample)
    );
endmodule
`default_nettype wire
